@@ hw/rtl/xtea_pkg.sv @@
// ============================================================================
// XTEA package
// Shared word types, key constants and the pipeline stage record.
// ============================================================================
package xtea_pkg;

    localparam int XTEA_WORD_W     = 32;
    localparam int XTEA_KEY_WORDS  = 4;
    localparam int XTEA_CFG_IDX_W  = 2;
    localparam int XTEA_ROUNDS_DEF = 32;

    typedef logic [XTEA_WORD_W-1:0] t_word;
    typedef logic [XTEA_KEY_WORDS-1:0][XTEA_WORD_W-1:0] t_key;

    localparam t_word XTEA_DELTA = 32'h9E37_79B9;

    // Word 0 sits in the lowest slot.
    localparam t_key XTEA_KEY_RST = {32'h3C2D_1E0F, 32'h7869_5A4B,
                                     32'hB4A5_9687, 32'hF0E1_D2C3};

    typedef enum logic [XTEA_CFG_IDX_W-1:0] {
        KEY_WORD_0 = 2'd0,
        KEY_WORD_1 = 2'd1,
        KEY_WORD_2 = 2'd2,
        KEY_WORD_3 = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        KIND_ENCRYPT = 1'b0,
        KIND_DECRYPT = 1'b1
    } t_kind;

    // Everything one block carries from cell to cell.
    typedef struct packed {
        logic  valid;
        t_kind kind;
        t_word a;
        t_word b;
        t_word acc;
    } t_stage;

endpackage

@@ hw/rtl/xtea_in_if.sv @@
// ============================================================================
// XTEA input channel
// Valid/ready channel carrying one plaintext or ciphertext block.
// ============================================================================
interface xtea_in_if;
    import xtea_pkg::*;

    logic  valid;
    logic  ready;
    logic  kind;
    t_word first_word;
    t_word second_word;

    modport source (output valid, kind, first_word, second_word, input ready);
    modport sink   (input valid, kind, first_word, second_word, output ready);
endinterface

@@ hw/rtl/xtea_out_if.sv @@
// ============================================================================
// XTEA output channel
// Valid/ready channel carrying one transformed block.
// ============================================================================
interface xtea_out_if;
    import xtea_pkg::*;

    logic  valid;
    logic  ready;
    t_word out_first_word;
    t_word out_second_word;

    modport source (output valid, out_first_word, out_second_word, input ready);
    modport sink   (input valid, out_first_word, out_second_word, output ready);
endinterface

@@ hw/rtl/xtea_round_cell.sv @@
// ============================================================================
// XTEA half-round cell
// One Feistel half-round with a register on its output.
// ============================================================================
module xtea_round_cell #(
    parameter bit P_SECOND = 1'b0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  xtea_pkg::t_key   i_key,
    input  xtea_pkg::t_stage i_stage,
    output xtea_pkg::t_stage o_stage
);
    import xtea_pkg::*;

    t_stage r_stage;
    t_stage n_stage;
    logic   sel_b;
    t_word  src;
    t_word  tgt;
    t_word  mix;
    t_word  kword;
    t_word  f;
    t_word  upd;

    // Encrypt first halves and decrypt second halves update a from b;
    // the other two update b from a with the key picked by bits 12:11.
    always_comb begin
        sel_b = (i_stage.kind == KIND_DECRYPT) ^ P_SECOND;
        src   = sel_b ? i_stage.a : i_stage.b;
        tgt   = sel_b ? i_stage.b : i_stage.a;
        kword = sel_b ? i_key[i_stage.acc[12:11]] : i_key[i_stage.acc[1:0]];
        mix   = ((src << 4) ^ (src >> 5)) + src;
        f     = mix ^ (i_stage.acc + kword);
        upd   = (i_stage.kind == KIND_DECRYPT) ? tgt - f : tgt + f;

        n_stage = i_stage;
        if (sel_b) begin
            n_stage.b = upd;
        end else begin
            n_stage.a = upd;
        end
        if (!P_SECOND) begin
            n_stage.acc = (i_stage.kind == KIND_DECRYPT) ? i_stage.acc - XTEA_DELTA
                                                         : i_stage.acc + XTEA_DELTA;
        end
    end

    // Only the valid flag is reset; the data fields just follow the row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage.valid <= n_stage.valid;
        end
        if (i_en) begin
            r_stage.kind <= n_stage.kind;
            r_stage.a    <= n_stage.a;
            r_stage.b    <= n_stage.b;
            r_stage.acc  <= n_stage.acc;
        end
    end

    assign o_stage = r_stage;
endmodule

@@ hw/rtl/xtea_block_cipher.sv @@
// ============================================================================
// XTEA block cipher
// Pipelined 64-bit XTEA encrypt/decrypt, one half-round per cell.
// ============================================================================
//
//  Channel  Dir  Handshake            Contents
//  -------  ---  -------------------  ------------------------------------------
//  i_blk    in   valid/ready          kind, first_word, second_word
//  o_blk    out  valid/ready          out_first_word, out_second_word
//  i_cfg_*  in   write enable only    register index, 32-bit key word
//
// The core accepts one block per clock cycle while input ready is high. Each
// block passes through a row of 2*ROUNDS half-round cells and then the output
// register, by way of the skid register when the output is stalled.
// Reset loads the default key and empties every cell, the output register and
// the skid register. When the output is stalled one extra result lands in the
// skid register and input ready then drops until the skid register drains.
//
module xtea_block_cipher #(
    parameter int ROUNDS = xtea_pkg::XTEA_ROUNDS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [xtea_pkg::XTEA_CFG_IDX_W-1:0] i_cfg_idx,
    input  xtea_pkg::t_word                     i_cfg_data,
    xtea_in_if.sink                             i_blk,
    xtea_out_if.source                          o_blk
);
    import xtea_pkg::*;

    localparam int    L_CELLS   = 2 * ROUNDS;
    // Decryption starts with the sum the encryption ends with.
    localparam t_word L_DEC_SUM = t_word'(64'(XTEA_DELTA) * 64'(ROUNDS));

    t_key   r_key;
    t_stage w_stage [0:L_CELLS];
    logic   en;
    logic   take_last;
    logic   out_free;
    logic   r_out_valid;
    t_word  r_out_a;
    t_word  r_out_b;
    logic   r_skid_valid;
    t_word  r_skid_a;
    t_word  r_skid_b;

    // Key registers. Users must write only while the core is idle; unenforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= XTEA_KEY_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                KEY_WORD_0: r_key[0] <= i_cfg_data;
                KEY_WORD_1: r_key[1] <= i_cfg_data;
                KEY_WORD_2: r_key[2] <= i_cfg_data;
                KEY_WORD_3: r_key[3] <= i_cfg_data;
                default:    r_key    <= r_key;
            endcase
        end
    end

    // The whole row advances together unless the skid register holds a result.
    // Since that flag is a register, input ready never depends on output ready.
    assign en          = !r_skid_valid;
    assign i_blk.ready = en;

    always_comb begin
        w_stage[0].valid = i_blk.valid && en;
        w_stage[0].kind  = t_kind'(i_blk.kind);
        w_stage[0].a     = i_blk.first_word;
        w_stage[0].b     = i_blk.second_word;
        w_stage[0].acc   = (i_blk.kind == KIND_DECRYPT) ? L_DEC_SUM : '0;
    end

    // Even cells do the first half of a round, odd cells the second half.
    for (genvar g = 0; g < L_CELLS; g++) begin : g_cell
        xtea_round_cell #(
            .P_SECOND (1'(g % 2))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_key   (r_key),
            .i_stage (w_stage[g]),
            .o_stage (w_stage[g+1])
        );
    end

    // A result leaving the last cell goes to the output register when that is
    // free or being drained, and to the skid register otherwise.
    assign take_last = en && w_stage[L_CELLS].valid;
    assign out_free  = !r_out_valid || o_blk.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid  <= r_skid_valid || take_last;
                r_skid_valid <= 1'b0;
            end else if (take_last) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_a <= r_skid_a;
                r_out_b <= r_skid_b;
            end else begin
                r_out_a <= w_stage[L_CELLS].a;
                r_out_b <= w_stage[L_CELLS].b;
            end
        end else if (take_last) begin
            r_skid_a <= w_stage[L_CELLS].a;
            r_skid_b <= w_stage[L_CELLS].b;
        end
    end

    assign o_blk.valid           = r_out_valid;
    assign o_blk.out_first_word  = r_out_a;
    assign o_blk.out_second_word = r_out_b;
endmodule

@@ hw/rtl/xtea_checker.sv @@
// ============================================================================
// XTEA port checker
// Watches the block channels of the cipher top level over time.
// ============================================================================
module xtea_checker #(
    parameter int ROUNDS = xtea_pkg::XTEA_ROUNDS_DEF
) (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input xtea_pkg::t_word i_out_first,
    input xtea_pkg::t_word i_out_second
);
    import xtea_pkg::*;

    // Cells plus output and skid registers.
    localparam int L_CAP = 2 * ROUNDS + 2;

    logic [7:0] r_count;

    // Words accepted and not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= r_count + 8'(i_in_valid && i_in_ready)
                               - 8'(i_out_valid && i_out_ready);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_first) && $stable(i_out_second))
        else $error("output word changed while stalled");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_count != 8'd0)
        else $error("output word without an accepted input word");

    a_ready_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled while the output is empty");

    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 8'(L_CAP))
        else $error("more words in flight than the pipeline holds");
endmodule

bind xtea_block_cipher xtea_checker #(
    .ROUNDS (ROUNDS)
) u_xtea_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_blk.valid),
    .i_in_ready   (i_blk.ready),
    .i_out_valid  (o_blk.valid),
    .i_out_ready  (o_blk.ready),
    .i_out_first  (o_blk.out_first_word),
    .i_out_second (o_blk.out_second_word)
);
